// ----- hw/rtl/pafk_pkg.sv -----
// Package for the planar arm forward kinematics block.
// Holds widths, CORDIC constants and the arctangent table.
// No dependencies.
package pafk_pkg;

   // Field and datapath widths
   localparam int PAFK_JOINT_BITS = 16;
   localparam int PAFK_TIP_BITS   = 16;
   localparam int PAFK_Q30_BITS   = 32;
   localparam int PAFK_SUM_BITS   = 34;

   // Default parameter values
   localparam int PAFK_ANGLE_BITS    = 16;
   localparam int PAFK_CORDIC_STAGES = 16;

   // Number of rotators, one per link
   localparam int PAFK_LANES = 3;

   // Inverse CORDIC gain (1/K) in Q2.30 (infinite-stage value)
   localparam int PAFK_TAB_LEN = 24;
   localparam logic signed [PAFK_Q30_BITS-1:0] PAFK_GAIN_Q30 = 32'sd652032874;

   typedef logic signed [PAFK_Q30_BITS-1:0] pafk_q30_type;
   typedef logic [PAFK_JOINT_BITS-1:0]      pafk_joint_type;
   typedef logic signed [PAFK_TIP_BITS-1:0] pafk_tip_type;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] PAFK_ATAN_TURN32 [PAFK_TAB_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

endpackage

// ----- hw/rtl/planar_arm_forward_kinematics.sv -----
// Planar three-joint arm forward kinematics: three joint angles in, tip (x, y) out.
// Instantiates pafk_front, a chain of pafk_cell and pafk_back. Uses pafk_pkg.
//
// Takes one joint vector per cycle and returns one Q1.15 tip position per vector,
// in order. Angles are binary (65536 is a full turn) and their running sums wrap.
// Each link angle drives its own CORDIC lane; one cell per micro-rotation, so a
// vector passes the front register, min(CORDIC_STAGES, 24) cell registers and the
// three back stages from input transfer to output valid. Throughput is one
// transfer per cycle whenever the result side takes results; a stalled output
// fills the chain stage by stage before req_tready drops. +1.0 saturates to 32767.
module planar_arm_forward_kinematics import pafk_pkg::*; #(
   parameter int CORDIC_STAGES = PAFK_CORDIC_STAGES,
   parameter int ANGLE_BITS    = PAFK_ANGLE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // joint_angle_0 [15:0], joint_angle_1 [31:16],
                                    // joint_angle_2 [47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // tip_x [15:0], tip_y [31:16]
);

   localparam int NumCells = (CORDIC_STAGES < PAFK_TAB_LEN) ? CORDIC_STAGES : PAFK_TAB_LEN;

   pafk_joint_type             joint_angle [PAFK_LANES];
   logic                       valid_chain [NumCells+1];
   logic                       ready_chain [NumCells+1];
   pafk_q30_type               x_chain [NumCells+1][PAFK_LANES];
   pafk_q30_type               y_chain [NumCells+1][PAFK_LANES];
   logic signed [ANGLE_BITS:0] z_chain [NumCells+1][PAFK_LANES];
   logic                       flip_chain [NumCells+1][PAFK_LANES];
   pafk_tip_type               tip_x, tip_y;

   // Unpack the input transfer
   assign joint_angle[0] = req_tdata[15:0];
   assign joint_angle[1] = req_tdata[31:16];
   assign joint_angle[2] = req_tdata[47:32];

   pafk_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_angle  (joint_angle),
      .out_valid (valid_chain[0]),
      .out_ready (ready_chain[0]),
      .out_x     (x_chain[0]),
      .out_y     (y_chain[0]),
      .out_z     (z_chain[0]),
      .out_flip  (flip_chain[0])
   );

   // One cell per micro-rotation
   for (genvar k = 0; k < NumCells; k++) begin : g_cell
      pafk_cell #(.ANGLE_BITS(ANGLE_BITS), .STAGE(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[k]),
         .in_ready  (ready_chain[k]),
         .in_x      (x_chain[k]),
         .in_y      (y_chain[k]),
         .in_z      (z_chain[k]),
         .in_flip   (flip_chain[k]),
         .out_valid (valid_chain[k+1]),
         .out_ready (ready_chain[k+1]),
         .out_x     (x_chain[k+1]),
         .out_y     (y_chain[k+1]),
         .out_z     (z_chain[k+1]),
         .out_flip  (flip_chain[k+1])
      );
   end

   pafk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_chain[NumCells]),
      .in_ready  (ready_chain[NumCells]),
      .in_x      (x_chain[NumCells]),
      .in_y      (y_chain[NumCells]),
      .in_flip   (flip_chain[NumCells]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tip_x (tip_x),
      .out_tip_y (tip_y)
   );

   // Pack the result transfer
   assign rsp_tdata = {tip_y, tip_x};

endmodule

// ----- hw/rtl/pafk_front.sv -----
// Input stage: running joint angle sums, angle scaling and quadrant fold.
// Loads the start vector of the three CORDIC lanes. Uses pafk_pkg.
module pafk_front import pafk_pkg::*; #(
   parameter int ANGLE_BITS = PAFK_ANGLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pafk_joint_type        in_angle [PAFK_LANES],
   output logic                  out_valid,
   input  logic                  out_ready,
   output pafk_q30_type          out_x [PAFK_LANES],
   output pafk_q30_type          out_y [PAFK_LANES],
   output logic signed [ANGLE_BITS:0] out_z [PAFK_LANES],
   output logic                  out_flip [PAFK_LANES]
);

   logic                        valid_ff, valid_in;
   logic signed [ANGLE_BITS:0]  z_ff [PAFK_LANES];
   logic signed [ANGLE_BITS:0]  z_in [PAFK_LANES];
   logic                        flip_ff [PAFK_LANES];
   logic                        flip_in [PAFK_LANES];
   pafk_joint_type              sum_angle [PAFK_LANES];
   logic [ANGLE_BITS-1:0]       scaled [PAFK_LANES];

   // Running sums, wrapping modulo a full turn
   assign sum_angle[0] = in_angle[0];
   assign sum_angle[1] = sum_angle[0] + in_angle[1];
   assign sum_angle[2] = sum_angle[1] + in_angle[2];

   // Bring each sum to the angle width
   for (genvar l = 0; l < PAFK_LANES; l++) begin : g_scale
      if (ANGLE_BITS > PAFK_JOINT_BITS) begin : g_up
         assign scaled[l] = {sum_angle[l], {(ANGLE_BITS-PAFK_JOINT_BITS){1'b0}}};
      end else if (ANGLE_BITS == PAFK_JOINT_BITS) begin : g_same
         assign scaled[l] = sum_angle[l];
      end else begin : g_down
         assign scaled[l] = sum_angle[l][PAFK_JOINT_BITS-1 -: ANGLE_BITS];
      end
   end

   // Fold the second and third quadrants by half a turn; residual is sign-extended
   always_comb begin
      for (int l = 0; l < PAFK_LANES; l++) begin
         flip_in[l] = scaled[l][ANGLE_BITS-1] ^ scaled[l][ANGLE_BITS-2];
         z_in[l]    = {{3{scaled[l][ANGLE_BITS-2]}}, scaled[l][ANGLE_BITS-3:0]};
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         z_ff    <= z_in;
         flip_ff <= flip_in;
      end
   end

   assign out_valid = valid_ff;
   always_comb begin
      for (int l = 0; l < PAFK_LANES; l++) begin
         out_x[l]    = PAFK_GAIN_Q30;
         out_y[l]    = '0;
         out_z[l]    = z_ff[l];
         out_flip[l] = flip_ff[l];
      end
   end

endmodule

// ----- hw/rtl/pafk_cell.sv -----
// One CORDIC micro-rotation for all three lanes, registered.
// Cells are chained; each passes its vectors on when the next has room. Uses pafk_pkg.
module pafk_cell import pafk_pkg::*; #(
   parameter int ANGLE_BITS = PAFK_ANGLE_BITS,
   parameter int STAGE      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pafk_q30_type          in_x [PAFK_LANES],
   input  pafk_q30_type          in_y [PAFK_LANES],
   input  logic signed [ANGLE_BITS:0] in_z [PAFK_LANES],
   input  logic                  in_flip [PAFK_LANES],
   output logic                  out_valid,
   input  logic                  out_ready,
   output pafk_q30_type          out_x [PAFK_LANES],
   output pafk_q30_type          out_y [PAFK_LANES],
   output logic signed [ANGLE_BITS:0] out_z [PAFK_LANES],
   output logic                  out_flip [PAFK_LANES]
);

   // Rounded arctangent step in angle units
   localparam logic [32:0] StepWide =
      ({1'b0, PAFK_ATAN_TURN32[STAGE]} + (33'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
   localparam logic signed [ANGLE_BITS:0] Step = StepWide[ANGLE_BITS:0];

   logic                       valid_ff, valid_in;
   pafk_q30_type               x_ff [PAFK_LANES];
   pafk_q30_type               x_in [PAFK_LANES];
   pafk_q30_type               y_ff [PAFK_LANES];
   pafk_q30_type               y_in [PAFK_LANES];
   logic signed [ANGLE_BITS:0] z_ff [PAFK_LANES];
   logic signed [ANGLE_BITS:0] z_in [PAFK_LANES];
   logic                       flip_ff [PAFK_LANES];
   pafk_q30_type               dx, dy;

   // Micro-rotation; arithmetic shifts floor toward minus infinity
   always_comb begin
      dx = '0;
      dy = '0;
      for (int l = 0; l < PAFK_LANES; l++) begin
         dx = in_y[l] >>> STAGE;
         dy = in_x[l] >>> STAGE;
         if (!in_z[l][ANGLE_BITS]) begin
            x_in[l] = in_x[l] - dx;
            y_in[l] = in_y[l] + dy;
            z_in[l] = in_z[l] - Step;
         end else begin
            x_in[l] = in_x[l] + dx;
            y_in[l] = in_y[l] - dy;
            z_in[l] = in_z[l] + Step;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         flip_ff <= in_flip;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_flip  = flip_ff;

endmodule

// ----- hw/rtl/pafk_back.sv -----
// Output stages: undo the fold, sum the three lanes, divide by 3*2^15 with
// rounding and saturate to Q1.15. Three registered stages. Uses pafk_pkg.
module pafk_back import pafk_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  pafk_q30_type in_x [PAFK_LANES],
   input  pafk_q30_type in_y [PAFK_LANES],
   input  logic         in_flip [PAFK_LANES],
   output logic         out_valid,
   input  logic         out_ready,
   output pafk_tip_type out_tip_x,
   output pafk_tip_type out_tip_y
);

   // floor(q/3) as (q + Bias) * Recip >> 24, then minus Bias/3
   localparam int QuotBits = 19;
   localparam int UBits    = 22;
   localparam int RBits    = 23;
   localparam int PBits    = UBits + RBits;
   localparam logic [UBits-1:0] Bias     = 22'd786432;
   localparam logic [RBits-1:0] Recip    = 23'd5592406;
   localparam logic signed [PAFK_SUM_BITS-1:0] RoundAdd = 34'sd49152;
   localparam logic signed [PBits-24:0] BiasDiv3 = 22'sd262144;
   localparam logic signed [PBits-24:0] TipMax   = 22'sd32767;
   localparam logic signed [PBits-24:0] TipMin   = -22'sd32768;

   logic                            a_valid_ff, a_valid_in, a_ready;
   logic                            b_valid_ff, b_valid_in, b_ready;
   logic                            c_valid_ff, c_valid_in, c_ready;
   logic signed [PAFK_SUM_BITS-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [PBits-1:0]                px_ff, px_in, py_ff, py_in;
   pafk_tip_type                    tx_ff, tx_in, ty_ff, ty_in;

   // Stage A: sign fix and three-lane sum
   always_comb begin
      sx_in = '0;
      sy_in = '0;
      for (int l = 0; l < PAFK_LANES; l++) begin
         if (in_flip[l]) begin
            sx_in = sx_in - PAFK_SUM_BITS'(in_x[l]);
            sy_in = sy_in - PAFK_SUM_BITS'(in_y[l]);
         end else begin
            sx_in = sx_in + PAFK_SUM_BITS'(in_x[l]);
            sy_in = sy_in + PAFK_SUM_BITS'(in_y[l]);
         end
      end
   end

   // Stage B: round, drop 15 bits, bias positive, multiply by 1/3
   function automatic logic [PBits-1:0] scale3(input logic signed [PAFK_SUM_BITS-1:0] s);
      logic signed [PAFK_SUM_BITS-1:0] r;
      logic signed [QuotBits-1:0]      q;
      logic [UBits-1:0]                u;
      r = s + RoundAdd;
      q = r[PAFK_SUM_BITS-1:15];
      u = UBits'(q) + Bias;
      return PBits'(u) * PBits'(Recip);
   endfunction

   assign px_in = scale3(sx_ff);
   assign py_in = scale3(sy_ff);

   // Stage C: take quotient, remove bias, saturate
   function automatic pafk_tip_type sat3(input logic [PBits-1:0] p);
      logic signed [PBits-24:0] d;
      d = $signed({1'b0, p[PBits-1:24]}) - BiasDiv3;
      if (d > TipMax) begin
         return TipMax[PAFK_TIP_BITS-1:0];
      end else if (d < TipMin) begin
         return TipMin[PAFK_TIP_BITS-1:0];
      end
      return d[PAFK_TIP_BITS-1:0];
   endfunction

   assign tx_in = sat3(px_ff);
   assign ty_in = sat3(py_ff);

   // Stall chain
   assign c_ready    = !c_valid_ff || out_ready;
   assign b_ready    = !b_valid_ff || c_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign in_ready   = a_ready;
   assign a_valid_in = a_ready ? in_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
      if (b_ready && a_valid_ff) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
      if (c_ready && b_valid_ff) begin
         tx_ff <= tx_in;
         ty_ff <= ty_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_tip_x = tx_ff;
   assign out_tip_y = ty_ff;

endmodule
